// ----- hw/rtl/gsrb_pkg.sv -----
// Shared types, codes and constants for the gamepad slot report bridge.
// No dependencies; imported by every module of the block.
`default_nettype none

package gsrb_pkg;

    localparam int SLOTS_DEF   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int REPORT_LEN  = 14;
    localparam int BUF_DEPTH   = 13;
    localparam logic [4:0] COUNT_MAX = 5'd31;
    localparam logic [7:0] FMT_MARK  = 8'h14;

    localparam logic [1:0] FUNC_MOUNT   = 2'd0;
    localparam logic [1:0] FUNC_UNMOUNT = 2'd1;
    localparam logic [1:0] FUNC_REPORT  = 2'd2;

    localparam logic [2:0] ST_IGNORED   = 3'd0;
    localparam logic [2:0] ST_MOUNTED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_UNMOUNTED = 3'd3;
    localparam logic [2:0] ST_BYTE      = 3'd4;
    localparam logic [2:0] ST_STORED    = 3'd5;
    localparam logic [2:0] ST_BAD_FMT   = 3'd6;
    localparam logic [2:0] ST_NO_SLOT   = 3'd7;

    localparam logic [1:0] NO_SLOT = 2'd3;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_MOUNT   = 3'd1;
    localparam logic [2:0] CMD_UNMOUNT = 3'd2;
    localparam logic [2:0] CMD_BYTE    = 3'd3;
    localparam logic [2:0] CMD_REPORT  = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [6:0]  bus_addr;
        logic [7:0]  instance_req;
        logic        is_console_type;
        logic [7:0]  subtype;
        logic        has_ids;
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic [7:0]  report_byte;
        logic        byte_last;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  slot_index;
        logic        route_valid;
        logic [3:0]  dpad;
        logic [12:0] button_bits;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
        logic [15:0] left_x;
        logic [15:0] left_y;
        logic [15:0] right_x;
        logic [15:0] right_y;
    } t_rsp;

    // classified request handed from front to back
    typedef struct packed {
        logic [2:0]  kind;
        logic        fmt_ok;
        logic [6:0]  bus_addr;
        logic [7:0]  iface;
        logic [16:0] keys;
        logic [15:0] trig;
        logic [63:0] sticks;
    } t_cmd;

endpackage

`default_nettype wire

// ----- hw/rtl/gamepad_slot_report_bridge.sv -----
// Path: an accepted request is written into the queue, then popped by the back end,
// which loads its result into the o_rsp register once that register is free.
// Throughput: one request per cycle while results are taken; the two-entry
// queue holds up to two requests behind a stalled o_rsp.
// Reset: synchronous, active low; empties slot table, collector and queue.
// Top level: front end, queue and back end. Depends on gsrb_pkg.
`default_nettype none

module gamepad_slot_report_bridge #(
    parameter int SLOTS = gsrb_pkg::SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  gsrb_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output gsrb_pkg::t_rsp  o_rsp
);
    import gsrb_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic push;
    logic pop;
    logic q_ready;
    logic q_valid;

    gsrb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .i_q_ready   (q_ready),
        .o_req_ready (o_req_ready),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    gsrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    gsrb_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/gsrb_front.sv -----
// Front end: report byte collector, decoder and request classifier.
// Depends on gsrb_pkg; feeds gsrb_queue.
`default_nettype none

module gsrb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  gsrb_pkg::t_req  i_req,
    input  logic            i_q_ready,
    output logic            o_req_ready,
    output logic            o_push,
    output gsrb_pkg::t_cmd  o_cmd
);
    import gsrb_pkg::*;

    logic [4:0]  r_count;
    logic [4:0]  n_count;
    logic [7:0]  r_buf [BUF_DEPTH];
    logic [7:0]  eff [BUF_DEPTH];
    logic [3:0]  wr_pos;
    logic        take;
    logic        is_byte;
    logic        store_byte;
    logic [15:0] b;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [7:0]  lt;
    logic [7:0]  rt;
    logic [12:0] btn;

    assign o_req_ready = i_q_ready;
    assign take        = i_req_valid && i_q_ready;
    assign o_push      = take;
    assign is_byte     = (i_req.func == FUNC_REPORT);
    assign store_byte  = take && is_byte && (r_count != 5'd0) &&
                         (r_count < 5'(REPORT_LEN));
    assign wr_pos      = r_count[3:0] - 4'd1;

    // buffer as it stands once the current byte is written
    always_comb begin
        for (int j = 0; j < BUF_DEPTH; j++) begin
            eff[j] = (r_count == 5'(j + 1)) ? i_req.report_byte : r_buf[j];
        end
    end

    always_comb begin
        b   = {eff[2], eff[1]};
        lt  = eff[3];
        rt  = eff[4];
        lx  = {eff[6], eff[5]};
        ly  = {eff[8], eff[7]};
        rx  = {eff[10], eff[9]};
        ry  = {eff[12], eff[11]};
        btn = {rt != 8'd0, lt != 8'd0, b[15:12], b[10:4]};

        o_cmd.bus_addr = i_req.bus_addr;
        o_cmd.iface    = i_req.instance_req;
        o_cmd.keys     = {btn, b[3:0]};
        o_cmd.trig     = {rt, lt};
        // x + 32768 flips the sign bit; 32767 - y inverts the low 15 bits
        o_cmd.sticks   = {ry[15], ~ry[14:0], ~rx[15], rx[14:0],
                          ly[15], ~ly[14:0], ~lx[15], lx[14:0]};
        o_cmd.fmt_ok   = (r_count >= 5'(REPORT_LEN - 1)) && (eff[0] == FMT_MARK);

        unique case (i_req.func)
            FUNC_MOUNT: begin
                o_cmd.kind = (i_req.is_console_type &&
                              (i_req.subtype != 8'd0 || i_req.instance_req == 8'd0))
                             ? CMD_MOUNT : CMD_NONE;
            end
            FUNC_UNMOUNT: o_cmd.kind = CMD_UNMOUNT;
            FUNC_REPORT:  o_cmd.kind = i_req.byte_last ? CMD_REPORT : CMD_BYTE;
            default:      o_cmd.kind = CMD_NONE;
        endcase

        if (i_req.byte_last) begin
            n_count = 5'd0;
        end else if (r_count < COUNT_MAX) begin
            n_count = r_count + 5'd1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd0;
        end else if (take && is_byte) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_byte) begin
            r_buf[wr_pos] <= i_req.report_byte;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gsrb_queue.sv -----
// Short request queue between the front end and the slot table back end.
// Depends on gsrb_pkg.
`default_nettype none

module gsrb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gsrb_pkg::t_cmd  i_cmd,
    output logic            o_ready,
    output logic            o_valid,
    output gsrb_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import gsrb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gsrb_back.sv -----
// Back end: slot table lookup, mount, unmount, report store and result register.
// Depends on gsrb_pkg; takes requests from gsrb_queue.
`default_nettype none

module gsrb_back #(
    parameter int SLOTS = gsrb_pkg::SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  gsrb_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output gsrb_pkg::t_rsp  o_rsp
);
    import gsrb_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0] r_used;
    logic [SLOTS-1:0] r_has;
    logic [6:0]       r_addr   [SLOTS];
    logic [7:0]       r_iface  [SLOTS];
    logic [16:0]      r_keys   [SLOTS];
    logic [15:0]      r_trig   [SLOTS];
    logic [63:0]      r_sticks [SLOTS];
    logic             r_rsp_valid;
    logic [2:0]       r_status;
    logic [1:0]       r_idx;

    logic [2:0]       n_status;
    logic [1:0]       n_idx;
    logic             adv;
    logic             hit;
    logic             free;
    logic [SW-1:0]    hit_sel;
    logic [SW-1:0]    free_sel;
    logic [SLOTS-1:0] mount_en;
    logic [SLOTS-1:0] clr_en;
    logic [SLOTS-1:0] store_en;
    logic             route;

    assign adv   = i_q_valid && (!r_rsp_valid || i_rsp_ready);
    assign o_pop = adv;

    always_comb begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_sel  = '0;
        free_sel = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_used[i] && r_addr[i] == i_cmd.bus_addr && r_iface[i] == i_cmd.iface) begin
                hit     = 1'b1;
                hit_sel = SW'(i);
            end
            if (!r_used[i]) begin
                free     = 1'b1;
                free_sel = SW'(i);
            end
        end
    end

    always_comb begin
        n_status = ST_IGNORED;
        n_idx    = NO_SLOT;
        mount_en = '0;
        clr_en   = '0;
        store_en = '0;
        unique case (i_cmd.kind)
            CMD_MOUNT: begin
                if (hit) begin
                    n_status = ST_MOUNTED;
                    n_idx    = 2'(hit_sel);
                end else if (free) begin
                    n_status = ST_MOUNTED;
                    n_idx    = 2'(free_sel);
                    for (int i = 0; i < SLOTS; i++) begin
                        mount_en[i] = adv && (free_sel == SW'(i));
                    end
                end else begin
                    n_status = ST_FULL;
                end
            end
            CMD_UNMOUNT: begin
                n_status = ST_UNMOUNTED;
                for (int i = 0; i < SLOTS; i++) begin
                    clr_en[i] = adv && r_used[i] && (r_addr[i] == i_cmd.bus_addr);
                end
            end
            CMD_BYTE: n_status = ST_BYTE;
            CMD_REPORT: begin
                if (!hit) begin
                    n_status = ST_NO_SLOT;
                end else if (!i_cmd.fmt_ok) begin
                    n_status = ST_BAD_FMT;
                end else begin
                    n_status = ST_STORED;
                    n_idx    = 2'(hit_sel);
                    for (int i = 0; i < SLOTS; i++) begin
                        store_en[i] = adv && (hit_sel == SW'(i));
                    end
                end
            end
            default: begin
                n_status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_has       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (clr_en[i]) begin
                    r_used[i] <= 1'b0;
                    r_has[i]  <= 1'b0;
                end else if (mount_en[i]) begin
                    r_used[i] <= 1'b1;
                    r_has[i]  <= 1'b0;
                end else if (store_en[i]) begin
                    r_has[i]  <= 1'b1;
                end
            end
            if (adv) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (mount_en[i]) begin
                r_addr[i]  <= i_cmd.bus_addr;
                r_iface[i] <= i_cmd.iface;
            end
            if (store_en[i]) begin
                r_keys[i]   <= i_cmd.keys;
                r_trig[i]   <= i_cmd.trig;
                r_sticks[i] <= i_cmd.sticks;
            end
        end
        if (adv) begin
            r_status <= n_status;
            r_idx    <= n_idx;
        end
    end

    // slot table only moves when a new result loads, so slot 0 matches it
    assign route       = r_used[0] && r_has[0];
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        o_rsp.status        = r_status;
        o_rsp.slot_index    = r_idx;
        o_rsp.route_valid   = route;
        o_rsp.dpad          = route ? r_keys[0][3:0]    : 4'd0;
        o_rsp.button_bits   = route ? r_keys[0][16:4]   : 13'd0;
        o_rsp.left_trigger  = route ? r_trig[0][7:0]    : 8'd0;
        o_rsp.right_trigger = route ? r_trig[0][15:8]   : 8'd0;
        o_rsp.left_x        = route ? r_sticks[0][15:0]  : 16'd0;
        o_rsp.left_y        = route ? r_sticks[0][31:16] : 16'd0;
        o_rsp.right_x       = route ? r_sticks[0][47:32] : 16'd0;
        o_rsp.right_y       = route ? r_sticks[0][63:48] : 16'd0;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gsrb_checker.sv -----
// Port-level checks for gamepad_slot_report_bridge, attached by bind.
// Depends on gsrb_pkg.
`default_nettype none

module gsrb_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    input  gsrb_pkg::t_rsp  o_rsp
);
    import gsrb_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    a_route_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp.route_valid |-> (o_rsp.dpad == 4'd0 && o_rsp.button_bits == 13'd0 &&
            o_rsp.left_trigger == 8'd0 && o_rsp.right_trigger == 8'd0 &&
            o_rsp.left_x == 16'd0 && o_rsp.left_y == 16'd0 &&
            o_rsp.right_x == 16'd0 && o_rsp.right_y == 16'd0))
        else $error("routed state not cleared without slot 0 data");

    a_idx_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_MOUNTED && o_rsp.status != ST_STORED
            |-> o_rsp.slot_index == NO_SLOT)
        else $error("slot index given without mount or store");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("result valid straight after reset");

endmodule

bind gamepad_slot_report_bridge gsrb_checker u_gsrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

`default_nettype wire

// ----- verif/gamepad_slot_report_bridge_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for gamepad_slot_report_bridge: a directed table with expected results, then random
// mount, unmount, report and other requests, checked against an in-bench slot table model.
// Depends on gsrb_pkg and the gamepad_slot_report_bridge RTL.

module gamepad_slot_report_bridge_test;
    import gsrb_pkg::*;

    localparam logic [1:0]  FUNC_SPARE   = 2'd3;
    localparam logic [15:0] ID_VENDOR    = 16'h045E;
    localparam logic [15:0] ID_PRODUCT   = 16'h028E;
    localparam int          RANDOM_ITEMS = 600;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          QUIET_LIMIT  = 2000;
    // sample report, byte 0 in the low bits
    localparam logic [14*8-1:0] SAMPLE_REPORT = {
        8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h80,
        8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h14, 8'h00};

    typedef enum int {RX_STEADY, RX_THREE_OF_FOUR, RX_COIN, RX_SPARSE} t_rx_style;

    typedef struct {
        t_req ev;
        bit   typed;
        t_rsp outcome;
    } t_step_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic i_rsp_ready = 1'b0;
    t_req i_req       = '0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // side info travelling with the request on the bus
    bit   ev_typed   = 1'b0;
    t_rsp ev_outcome = '0;

    // slot table model
    logic        tbl_used     [SLOTS_DEF];
    logic [6:0]  tbl_addr     [SLOTS_DEF];
    logic [7:0]  tbl_iface    [SLOTS_DEF];
    logic [7:0]  tbl_kind     [SLOTS_DEF];
    logic        tbl_has_data [SLOTS_DEF];
    logic [16:0] tbl_keys     [SLOTS_DEF];
    logic [15:0] tbl_trig     [SLOTS_DEF];
    logic [63:0] tbl_sticks   [SLOTS_DEF];
    logic [7:0]  report_buf   [BUF_DEPTH];
    logic [4:0]  report_count;

    t_rsp      outcome_q [$];
    t_step_row dir_rows  [$];
    int        mismatches  = 0;
    int        items_sent  = 0;
    int        burst_left  = 0;
    int        quiet_count = 0;
    bit        hold_go     = 1'b0;
    logic [6:0] pool_addr  [3];
    logic [7:0] pool_iface [3];

    gamepad_slot_report_bridge #(.SLOTS(SLOTS_DEF)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void clear_entry(int i);
        tbl_used[i]     = 1'b0;
        tbl_addr[i]     = '0;
        tbl_iface[i]    = '0;
        tbl_kind[i]     = '0;
        tbl_has_data[i] = 1'b0;
        tbl_keys[i]     = '0;
        tbl_trig[i]     = '0;
        tbl_sticks[i]   = '0;
    endfunction

    function automatic int find_slot(logic [6:0] a, logic [7:0] ifc);
        int hit;
        hit = -1;
        for (int i = SLOTS_DEF - 1; i >= 0; i--)
            if (tbl_used[i] && tbl_addr[i] == a && tbl_iface[i] == ifc)
                hit = i;
        return hit;
    endfunction

    function automatic t_rsp apply_event(t_req e);
        t_rsp        o;
        int          s;
        logic [15:0] b, lx, ly, rx, ry;
        logic [7:0]  lt, rt;
        logic [12:0] btn;
        o = '0;
        o.status = ST_IGNORED;
        o.slot_index = NO_SLOT;
        case (e.func)
            FUNC_MOUNT: begin
                if (e.is_console_type && (e.subtype != 0 || e.instance_req == 0)) begin
                    s = find_slot(e.bus_addr, e.instance_req);
                    for (int i = 0; i < SLOTS_DEF; i++) begin
                        if (!tbl_used[i] && s < 0) begin
                            clear_entry(i);
                            tbl_used[i]  = 1'b1;
                            tbl_addr[i]  = e.bus_addr;
                            tbl_iface[i] = e.instance_req;
                            tbl_kind[i]  = e.subtype;
                            s = i;
                        end
                    end
                    if (s < 0) begin
                        o.status = ST_FULL;
                    end else begin
                        o.status = ST_MOUNTED;
                        o.slot_index = s[1:0];
                    end
                end
            end
            FUNC_UNMOUNT: begin
                for (int i = 0; i < SLOTS_DEF; i++)
                    if (tbl_used[i] && tbl_addr[i] == e.bus_addr)
                        clear_entry(i);
                o.status = ST_UNMOUNTED;
            end
            FUNC_REPORT: begin
                if (report_count >= 1 && report_count < REPORT_LEN)
                    report_buf[report_count - 1] = e.report_byte;
                if (report_count < COUNT_MAX)
                    report_count++;
                if (!e.byte_last) begin
                    o.status = ST_BYTE;
                end else begin
                    s = find_slot(e.bus_addr, e.instance_req);
                    if (s < 0) begin
                        o.status = ST_NO_SLOT;
                    end else if (report_count < REPORT_LEN || report_buf[0] != FMT_MARK) begin
                        o.status = ST_BAD_FMT;
                    end else begin
                        b  = {report_buf[2], report_buf[1]};
                        lt = report_buf[3];
                        rt = report_buf[4];
                        lx = {report_buf[6], report_buf[5]} + 16'h8000;
                        ly = 16'h7FFF - {report_buf[8], report_buf[7]};
                        rx = {report_buf[10], report_buf[9]} + 16'h8000;
                        ry = 16'h7FFF - {report_buf[12], report_buf[11]};
                        // guide bit 11 has no place in the button map
                        btn = {rt != 0, lt != 0, b[15:12], b[10:4]};
                        tbl_keys[s]     = {btn, b[3:0]};
                        tbl_trig[s]     = {rt, lt};
                        tbl_sticks[s]   = {ry, rx, ly, lx};
                        tbl_has_data[s] = 1'b1;
                        o.status = ST_STORED;
                        o.slot_index = s[1:0];
                    end
                    report_count = '0;
                end
            end
            default: ;
        endcase
        if (tbl_used[0] && tbl_has_data[0]) begin
            o.route_valid   = 1'b1;
            o.dpad          = tbl_keys[0][3:0];
            o.button_bits   = tbl_keys[0][16:4];
            o.left_trigger  = tbl_trig[0][7:0];
            o.right_trigger = tbl_trig[0][15:8];
            o.left_x        = tbl_sticks[0][15:0];
            o.left_y        = tbl_sticks[0][31:16];
            o.right_x       = tbl_sticks[0][47:32];
            o.right_y       = tbl_sticks[0][63:48];
        end
        return o;
    endfunction

    function automatic t_req ev_of(logic [1:0] f, logic [6:0] a, logic [7:0] ifc, logic c,
                                   logic [7:0] st, logic ids, logic [15:0] v, logic [15:0] p,
                                   logic [7:0] rb, logic lst);
        t_req e;
        e = '{f, a, ifc, c, st, ids, v, p, rb, lst};
        return e;
    endfunction

    function automatic t_rsp plain_outcome(logic [2:0] st, logic [1:0] idx);
        t_rsp o;
        o = '0;
        o.status = st;
        o.slot_index = idx;
        return o;
    endfunction

    function automatic t_req random_fill();
        t_req e;
        e.func            = 2'($urandom);
        e.bus_addr        = 7'($urandom);
        e.instance_req    = 8'($urandom);
        e.is_console_type = 1'($urandom);
        e.subtype         = 8'($urandom);
        e.has_ids         = 1'($urandom);
        e.vendor_id       = 16'($urandom);
        e.product_id      = 16'($urandom);
        e.report_byte     = 8'($urandom);
        e.byte_last       = 1'($urandom);
        return e;
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0: v = 8'h00;
                1: v = 8'hFF;
                2: v = 8'h80;
                default: v = 8'h7F;
            endcase
        end
        return v;
    endfunction

    task automatic check_field(string nm, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
            mismatches++;
        end
    endtask

    // request capture and result checking
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp pred;
        if (i_rst_n) begin
            if (i_req_valid && o_req_ready) begin
                pred = apply_event(i_req);
                outcome_q.push_back(ev_typed ? ev_outcome : pred);
            end
            if (o_rsp_valid && i_rsp_ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %0h", $time, o_rsp);
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status",        want.status,        o_rsp.status);
                    check_field("slot_index",    want.slot_index,    o_rsp.slot_index);
                    check_field("route_valid",   want.route_valid,   o_rsp.route_valid);
                    check_field("dpad",          want.dpad,          o_rsp.dpad);
                    check_field("button_bits",   want.button_bits,   o_rsp.button_bits);
                    check_field("left_trigger",  want.left_trigger,  o_rsp.left_trigger);
                    check_field("right_trigger", want.right_trigger, o_rsp.right_trigger);
                    check_field("left_x",        want.left_x,        o_rsp.left_x);
                    check_field("left_y",        want.left_y,        o_rsp.left_y);
                    check_field("right_x",       want.right_x,       o_rsp.right_x);
                    check_field("right_y",       want.right_y,       o_rsp.right_y);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int        cyc;
        t_rx_style style;
        cyc = 0;
        style = RX_STEADY;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                i_rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                cyc++;
                if (cyc % 64 == 0)
                    style = t_rx_style'($urandom_range(0, 3));
                case (style)
                    RX_STEADY:        i_rsp_ready <= 1'b1;
                    RX_THREE_OF_FOUR: i_rsp_ready <= (cyc % 4 != 3);
                    RX_COIN:          i_rsp_ready <= 1'($urandom_range(0, 1));
                    default:          i_rsp_ready <= (cyc % 5 == 0);
                endcase
            end
        end
    end

    task automatic send_item(t_req ev, bit typed, t_rsp outcome);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 16);
        end
        i_req_valid <= 1'b1;
        i_req       <= ev;
        ev_typed    <= typed;
        ev_outcome  <= outcome;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        burst_left--;
        if (ev.func != FUNC_SPARE)
            items_sent++;
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic pick_key(output logic [6:0] a, output logic [7:0] ifc);
        a   = pool_addr[$urandom_range(0, 2)];
        ifc = pool_iface[$urandom_range(0, 2)];
    endtask

    task automatic rand_mount();
        t_req       ev;
        logic [6:0] a;
        logic [7:0] ifc;
        ev = random_fill();
        pick_key(a, ifc);
        ev.func = FUNC_MOUNT;
        ev.bus_addr = a;
        ev.instance_req = ifc;
        ev.is_console_type = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 2) == 0)
            ev.subtype = '0;
        if ($urandom_range(0, 3) == 0) begin
            ev.has_ids = 1'b1;
            ev.vendor_id = ID_VENDOR;
            ev.product_id = ID_PRODUCT;
        end
        send_item(ev, 1'b0, '0);
    endtask

    task automatic rand_unmount();
        t_req ev;
        ev = random_fill();
        ev.func = FUNC_UNMOUNT;
        if ($urandom_range(0, 4) != 0)
            ev.bus_addr = pool_addr[$urandom_range(0, 2)];
        send_item(ev, 1'b0, '0);
    endtask

    task automatic rand_report();
        t_req       ev;
        logic [6:0] a;
        logic [7:0] ifc;
        int         len;
        int         r;
        pick_key(a, ifc);
        if ($urandom_range(0, 6) == 0) begin
            a = 7'($urandom);
            ifc = 8'($urandom);
        end
        r = $urandom_range(0, 99);
        len = (r < 70) ? REPORT_LEN : (r < 85) ? $urandom_range(1, REPORT_LEN - 1)
                                               : $urandom_range(REPORT_LEN + 1, 40);
        for (int k = 0; k < len; k++) begin
            ev = random_fill();
            ev.func = FUNC_REPORT;
            ev.byte_last = (k == len - 1);
            if (ev.byte_last || $urandom_range(0, 9) < 7) begin
                ev.bus_addr = a;
                ev.instance_req = ifc;
            end
            if (k == 1)
                ev.report_byte = ($urandom_range(0, 9) != 0) ? FMT_MARK : rand_byte();
            else
                ev.report_byte = rand_byte();
            send_item(ev, 1'b0, '0);
            // slot traffic in the middle of a report
            if (!ev.byte_last && $urandom_range(0, 29) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    rand_mount();
                else
                    rand_unmount();
            end
        end
    endtask

    initial begin
        t_req ev;
        int   r;
        bit   hold_done;
        bit   drain_done;
        hold_done = 1'b0;
        drain_done = 1'b0;
        for (int i = 0; i < SLOTS_DEF; i++)
            clear_entry(i);
        for (int i = 0; i < BUF_DEPTH; i++)
            report_buf[i] = '0;
        report_count = '0;
        pool_iface[0] = '0;
        for (int i = 0; i < 3; i++) begin
            pool_addr[i] = 7'($urandom);
            if (i > 0)
                pool_iface[i] = 8'($urandom);
        end

        dir_rows.push_back('{ev_of(FUNC_SPARE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             plain_outcome(ST_IGNORED, NO_SLOT)});
        // wrong controller kind, then identity on a nonzero interface with no subtype
        dir_rows.push_back('{ev_of(FUNC_MOUNT, 5, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1,
                             plain_outcome(ST_IGNORED, NO_SLOT)});
        dir_rows.push_back('{ev_of(FUNC_MOUNT, 5, 2, 1, 0, 1, ID_VENDOR, ID_PRODUCT, 0, 0),
                             1'b1, plain_outcome(ST_IGNORED, NO_SLOT)});
        dir_rows.push_back('{ev_of(FUNC_MOUNT, 1, 0, 1, 0, 0, 0, 0, 0, 0), 1'b1,
                             plain_outcome(ST_MOUNTED, 2'd0)});
        dir_rows.push_back('{ev_of(FUNC_MOUNT, 127, 255, 1, 255, 1, 16'hFFFF, 16'hFFFF,
                                   255, 1), 1'b1, plain_outcome(ST_MOUNTED, 2'd1)});
        dir_rows.push_back('{ev_of(FUNC_MOUNT, 1, 0, 1, 8, 0, 0, 0, 0, 0), 1'b1,
                             plain_outcome(ST_MOUNTED, 2'd0)});
        dir_rows.push_back('{ev_of(FUNC_MOUNT, 2, 1, 1, 1, 0, 0, 0, 0, 0), 1'b1,
                             plain_outcome(ST_MOUNTED, 2'd2)});
        dir_rows.push_back('{ev_of(FUNC_MOUNT, 3, 1, 1, 1, 0, 0, 0, 0, 0), 1'b1,
                             plain_outcome(ST_FULL, NO_SLOT)});
        for (int k = 0; k < REPORT_LEN; k++)
            dir_rows.push_back('{ev_of(FUNC_REPORT, 1, 0, 0, 0, 0, 0, 0,
                                       SAMPLE_REPORT[k*8 +: 8], k == REPORT_LEN - 1),
                                 k != REPORT_LEN - 1, plain_outcome(ST_BYTE, NO_SLOT)});
        dir_rows.push_back('{ev_of(FUNC_UNMOUNT, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             plain_outcome(ST_UNMOUNTED, NO_SLOT)});
        dir_rows.push_back('{ev_of(FUNC_REPORT, 127, 255, 0, 0, 0, 0, 0, 8'h14, 1), 1'b1,
                             plain_outcome(ST_BAD_FMT, NO_SLOT)});
        dir_rows.push_back('{ev_of(FUNC_SPARE, 127, 255, 1, 255, 1, 16'hFFFF, 16'hFFFF,
                                   255, 1), 1'b1, plain_outcome(ST_IGNORED, NO_SLOT)});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_item(dir_rows[k].ev, dir_rows[k].typed, dir_rows[k].outcome);
        wait_drained();

        while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
            if (!hold_done && items_sent >= dir_rows.size() + 200) begin
                hold_done = 1'b1;
                hold_go = 1'b1;
                burst_left = 200;
            end
            if (!drain_done && items_sent >= dir_rows.size() + 400) begin
                drain_done = 1'b1;
                wait_drained();
            end
            if ($urandom_range(0, 99) == 0) begin
                pool_addr[$urandom_range(0, 2)] = 7'($urandom);
                pool_iface[$urandom_range(1, 2)] = 8'($urandom);
            end
            r = $urandom_range(0, 99);
            if (r < 25) begin
                rand_mount();
            end else if (r < 35) begin
                rand_unmount();
            end else if (r < 85) begin
                rand_report();
            end else if (r < 92) begin
                ev = random_fill();
                ev.func = FUNC_SPARE;
                send_item(ev, 1'b0, '0);
            end else begin
                send_item(random_fill(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/gsrb_pkg.sv
hw/rtl/gsrb_front.sv
hw/rtl/gsrb_queue.sv
hw/rtl/gsrb_back.sv
hw/rtl/gamepad_slot_report_bridge.sv
hw/rtl/gsrb_checker.sv
verif/gamepad_slot_report_bridge_test.sv
